// ----- rtl/embedded_text_scanner_macros.svh -----
// Assertion macros shared by the scanner modules.
`ifndef EMBEDDED_TEXT_SCANNER_MACROS_SVH
`define EMBEDDED_TEXT_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ETS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ETS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ETS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ETS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/ets_pkg.sv -----
package ets_pkg;

  localparam int DEPTH_BITS     = 8;
  localparam int POSITION_BITS  = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = ~DEPTH_MAX;

  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_POUND  = 8'h23;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_LBRACK = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK = 8'h5D;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef enum logic [3:0] {
    CC_OTHER,
    CC_DQUOTE,
    CC_SQUOTE,
    CC_POUND,
    CC_LPAREN,
    CC_RPAREN,
    CC_LBRACK,
    CC_RBRACK,
    CC_LBRACE,
    CC_RBRACE,
    CC_SLASH,
    CC_STAR
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic        is_digit;
    logic        start;
  } ets_item_t;

endpackage

// ----- rtl/ets_front.sv -----
module ets_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        text_byte_i,
  input  logic              start_of_text_i,
  input  logic              full_i,
  output logic              push_o,
  output ets_pkg::ets_item_t item_o
);
  import ets_pkg::*;

  char_class_e cls;

  always_comb begin
    case (text_byte_i)
      CHAR_DQUOTE: cls = CC_DQUOTE;
      CHAR_SQUOTE: cls = CC_SQUOTE;
      CHAR_POUND:  cls = CC_POUND;
      CHAR_LPAREN: cls = CC_LPAREN;
      CHAR_RPAREN: cls = CC_RPAREN;
      CHAR_LBRACK: cls = CC_LBRACK;
      CHAR_RBRACK: cls = CC_RBRACK;
      CHAR_LBRACE: cls = CC_LBRACE;
      CHAR_RBRACE: cls = CC_RBRACE;
      CHAR_SLASH:  cls = CC_SLASH;
      CHAR_STAR:   cls = CC_STAR;
      default:     cls = CC_OTHER;
    endcase
  end

  assign item_o.cls      = cls;
  assign item_o.is_digit = (text_byte_i >= CHAR_ZERO) && (text_byte_i <= CHAR_NINE);
  assign item_o.start    = start_of_text_i;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// ----- rtl/ets_queue.sv -----
`include "embedded_text_scanner_macros.svh"

module ets_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ets_pkg::ets_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ets_pkg::ets_item_t item_o
);
  import ets_pkg::*;

  ets_item_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_BITS-1:0] cnt_q, cnt_d;

  localparam logic [QUEUE_PTR_BITS-1:0] PtrLast = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_BITS-1:0] CntFull = QUEUE_CNT_BITS'(QUEUE_DEPTH);

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `ETS_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, cnt_q != '0, "pop from empty queue")
  `ETS_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntFull, "queue count overrun")

endmodule

// ----- rtl/ets_back.sv -----
`include "embedded_text_scanner_macros.svh"

module ets_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  ets_pkg::ets_item_t              item_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ets_pkg::POSITION_BITS-1:0] position_o,
  output logic                            embedded_o
);
  import ets_pkg::*;

  typedef logic signed [DEPTH_BITS-1:0] depth_t;

  function automatic depth_t depth_step(depth_t d, logic up);
    depth_t r;
    r = d;
    if (up) begin
      if (d != DEPTH_MAX) r = d + depth_t'(1);
    end else begin
      if (d != DEPTH_MIN) r = d - depth_t'(1);
    end
    return r;
  endfunction

  function automatic logic depth_pos(depth_t d);
    return !d[DEPTH_BITS-1] && (d != '0);
  endfunction

  logic dq_q, dq_d, sq_q, sq_d, pounds_q, pounds_d, comment_q, comment_d;
  logic pend_q, pend_d, prev_unc_q, prev_unc_d;
  char_class_e prev_cls_q, prev_cls_d;
  depth_t paren_q, paren_d, brack_q, brack_d, brace_q, brace_d;
  logic [POSITION_BITS-1:0] cnt_q, cnt_d;

  logic out_valid_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic emb_q;

  // state as seen by this item, after an optional clear
  logic e_dq, e_sq, e_pounds, e_comment, e_prev_unc;
  char_class_e e_prev_cls;
  depth_t e_paren, e_brack, e_brace;
  logic [POSITION_BITS-1:0] e_cnt;
  logic open_ok, flag, cmt_open, cmt_close;

  assign pop_o = valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    e_dq       = item_i.start ? 1'b0 : dq_q;
    e_sq       = item_i.start ? 1'b0 : sq_q;
    e_comment  = item_i.start ? 1'b0 : comment_q;
    e_prev_unc = item_i.start ? 1'b0 : prev_unc_q;
    e_prev_cls = item_i.start ? CC_OTHER : prev_cls_q;
    e_paren    = item_i.start ? '0 : paren_q;
    e_brack    = item_i.start ? '0 : brack_q;
    e_brace    = item_i.start ? '0 : brace_q;
    e_cnt      = item_i.start ? '0 : cnt_q;
    // resolve a pending pound against this byte
    e_pounds   = item_i.start ? 1'b0 : (pounds_q || (pend_q && item_i.is_digit));

    flag = e_dq || e_sq || e_pounds || e_comment ||
           depth_pos(e_paren) || depth_pos(e_brack) || depth_pos(e_brace);

    open_ok   = !e_dq && !e_sq && !e_comment;
    cmt_open  = e_prev_unc && (e_prev_cls == CC_SLASH) && open_ok && (item_i.cls == CC_STAR);
    cmt_close = e_prev_unc && (e_prev_cls == CC_STAR) && e_comment &&
                (item_i.cls == CC_SLASH);
  end

  always_comb begin
    dq_d       = e_dq;
    sq_d       = e_sq;
    pounds_d   = e_pounds;
    comment_d  = e_comment;
    pend_d     = 1'b0;
    paren_d    = e_paren;
    brack_d    = e_brack;
    brace_d    = e_brace;
    cnt_d      = (e_cnt != '1) ? e_cnt + 1'b1 : e_cnt;
    prev_cls_d = item_i.cls;
    prev_unc_d = !(cmt_open || cmt_close);
    if (cmt_open) begin
      comment_d = 1'b1;
    end else if (cmt_close) begin
      comment_d = 1'b0;
    end else begin
      case (item_i.cls)
        CC_DQUOTE: if (!e_sq && !e_comment) dq_d = !e_dq;
        CC_SQUOTE: if (!e_dq && !e_comment) sq_d = !e_sq;
        CC_POUND: begin
          if (open_ok) begin
            if (e_pounds) pounds_d = 1'b0;
            else pend_d = 1'b1;
          end
        end
        CC_LPAREN: if (open_ok) paren_d = depth_step(e_paren, 1'b1);
        CC_RPAREN: if (open_ok) paren_d = depth_step(e_paren, 1'b0);
        CC_LBRACK: if (open_ok) brack_d = depth_step(e_brack, 1'b1);
        CC_RBRACK: if (open_ok) brack_d = depth_step(e_brack, 1'b0);
        CC_LBRACE: if (open_ok) brace_d = depth_step(e_brace, 1'b1);
        CC_RBRACE: if (open_ok) brace_d = depth_step(e_brace, 1'b0);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_q        <= 1'b0;
      sq_q        <= 1'b0;
      pounds_q    <= 1'b0;
      comment_q   <= 1'b0;
      pend_q      <= 1'b0;
      prev_unc_q  <= 1'b0;
      prev_cls_q  <= CC_OTHER;
      paren_q     <= '0;
      brack_q     <= '0;
      brace_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        dq_q       <= dq_d;
        sq_q       <= sq_d;
        pounds_q   <= pounds_d;
        comment_q  <= comment_d;
        pend_q     <= pend_d;
        prev_unc_q <= prev_unc_d;
        prev_cls_q <= prev_cls_d;
        paren_q    <= paren_d;
        brack_q    <= brack_d;
        brace_q    <= brace_d;
        cnt_q      <= cnt_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pos_q <= e_cnt;
      emb_q <= flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign embedded_o  = emb_q;

  `ETS_ASSERT_IMP(a_pop_only_free, clk_i, rst_ni, out_valid_q && out_stall_i, !pop_o, "pop while output held")
  `ETS_ASSERT_NXT(a_start_pos_zero, clk_i, rst_ni, pop_o && item_i.start, pos_q == '0, "start not at zero")

endmodule

// ----- rtl/embedded_text_scanner.sv -----
// SQL text scanner, one byte per item.
// Input channel: text_byte_i with start_of_text_i, handshake in_valid_i / in_stall_o.
// An item is taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: position_o and embedded_o, handshake out_valid_o / out_stall_i.
// embedded_o is high when the byte lies in quotes, a comment, a date literal
// or at a positive bracket depth, judged from the earlier bytes of the text.
// start_of_text_i clears all scan state before that byte is judged.
// A taken item is first written into the queue; its result is registered in the back end
// when the item is popped from the queue.
// Throughput: one item per cycle while out_stall_i is low, set by the state update
// in the back end; a four-entry queue sits between the classifier and the back end.
// When the receiver stalls, the result holds and the queue fills; in_stall_o
// rises once the queue is full and falls as soon as an entry drains.
// Reset clears the scan state, the queue and the output valid at once.
module embedded_text_scanner (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      text_byte_i,
  input  logic                            start_of_text_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ets_pkg::POSITION_BITS-1:0] position_o,
  output logic                            embedded_o
);
  import ets_pkg::*;

  logic      push, full, pop, q_valid;
  ets_item_t f_item, q_item;

  ets_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .start_of_text_i (start_of_text_i),
    .full_i          (full),
    .push_o          (push),
    .item_o          (f_item)
  );

  ets_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ets_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .position_o  (position_o),
    .embedded_o  (embedded_o)
  );

endmodule
